[rtl/core/cpu6502_alu_branch_ops_macros.svh]
// ---------------------------------------------------------------------------
// cpu6502_alu_branch_ops_macros.svh
// Assertion macros used by the checker file of the 6502 ALU/branch block.
// ---------------------------------------------------------------------------
`ifndef CPU6502_ALU_BRANCH_OPS_MACROS_SVH
`define CPU6502_ALU_BRANCH_OPS_MACROS_SVH

// Property checked while out of reset.
`define C6502_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define C6502_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/c6502_pkg.sv]
// ---------------------------------------------------------------------------
// c6502_pkg
// Types and constants shared by the 6502 ALU and branch execution block.
// ---------------------------------------------------------------------------
package c6502_pkg;

    typedef enum logic [3:0] {
        KIND_ADC     = 4'd0,
        KIND_AND     = 4'd1,
        KIND_ASL_A   = 4'd2,
        KIND_ASL_MEM = 4'd3,
        KIND_BIT     = 4'd4,
        KIND_BCC     = 4'd5,
        KIND_BCS     = 4'd6,
        KIND_BEQ     = 4'd7,
        KIND_BMI     = 4'd8,
        KIND_BNE     = 4'd9,
        KIND_BPL     = 4'd10,
        KIND_BVC     = 4'd11,
        KIND_BVS     = 4'd12,
        KIND_BRK     = 4'd13,
        KIND_INVALID = 4'd14
    } t_kind;

    // status register bit positions (NV-BDIZC)
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0]  STACK_PAGE      = 8'h01;
    localparam logic [7:0]  BRK_PUSH_MASK   = 8'h30;
    localparam logic [7:0]  ACC_RESET       = 8'h00;
    localparam logic [7:0]  STATUS_RESET    = 8'h24;
    localparam logic [15:0] PC_RESET        = 16'h0000;
    localparam logic [7:0]  SP_RESET        = 8'hFD;
    localparam logic [15:0] IRQ_VECTOR_RESET = 16'hFFFF;

    localparam logic [1:0]  BRK_LAST_BEAT   = 2'd2;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  status;
        logic [15:0] pc;
        logic [7:0]  sp;
    } t_cpu_state;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  operand;
        logic [15:0] effective_address;
        logic [1:0]  pc_step;
    } t_instr;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [7:0]  acc_out;
        logic [7:0]  status_out;
        logic [15:0] pc_out;
        logic        invalid;
    } t_result;

endpackage

[rtl/core/cpu6502_alu_branch_ops.sv]
// ---------------------------------------------------------------------------
// cpu6502_alu_branch_ops
// 6502 ADC/AND/ASL/BIT, flag branches and BRK with A, P, PC and SP held here.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Handshake
//  --------  ---------  ---------------------------------------  -------------
//  s_axis    in         tuser: kind; tdata: operand, ea, step    tvalid/tready
//  m_axis    out        tuser: we, invalid; tdata: write, state   tvalid/tready
//  cfg       in         IRQ vector (16 bits)                      write enable
//
//  An instruction goes through an input register, one pass of execute logic
//  and a result register. One instruction per cycle is taken while the
//  result stream keeps up; BRK holds the execute stage for one pass per
//  stack write, so it costs three result beats.
//  Reset (synchronous, active low) empties both registers and loads
//  A=0x00, P=0x24, PC=0x0000, SP=0xFD and the IRQ vector 0xFFFF.
//  A stalled output holds its beat; the input register fills and then
//  drops s_axis_tready until the result register frees up.
//
module cpu6502_alu_branch_ops (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: IRQ vector
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    // instruction stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] operand, [23:8] effective_address,
                                        // [25:24] pc_step, [31:26] zero
    input  logic [3:0]  s_axis_tuser,   // [3:0] kind
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [15:0] write_address, [23:16] write_data,
                                        // [31:24] acc_out, [39:32] status_out,
                                        // [55:40] pc_out
    output logic [1:0]  m_axis_tuser,   // [0] write_enable, [1] invalid
    output logic        m_axis_tlast
);

    // architectural state
    c6502_pkg::t_cpu_state r_state;
    logic [15:0]           r_irq_vector;

    // input register
    logic                  r_in_vld;
    c6502_pkg::t_instr     r_in;

    // execute sequencing (stack push beat for BRK)
    logic [1:0]            r_beat;
    logic [1:0]            n_beat;

    // result register
    logic                  r_out_vld;
    c6502_pkg::t_result    r_out;
    logic                  r_out_last;

    c6502_pkg::t_cpu_state exec_next;
    c6502_pkg::t_result    exec_result;
    logic                  exec_multi;
    logic                  out_free;
    logic                  exec_fire;
    logic                  exec_done;

    c6502_exec u_exec (
        .i_instr      (r_in),
        .i_state      (r_state),
        .i_irq_vector (r_irq_vector),
        .i_beat       (r_beat),
        .o_next       (exec_next),
        .o_result     (exec_result),
        .o_multi_beat (exec_multi)
    );

    // the result register takes a new beat when empty or being drained
    assign out_free  = !r_out_vld || m_axis_tready;
    assign exec_fire = r_in_vld && out_free;
    // an instruction retires on its only beat, or on the last BRK push
    assign exec_done = exec_fire && (!exec_multi || (r_beat == c6502_pkg::BRK_LAST_BEAT));
    assign n_beat    = exec_done ? 2'd0 : (r_beat + 2'd1);

    assign s_axis_tready = !r_in_vld || exec_done;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_vector <= c6502_pkg::IRQ_VECTOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_irq_vector <= i_cfg_wr_data;
        end
    end

    // input register: load on each accepted transaction, hold otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.kind              <= c6502_pkg::t_kind'(s_axis_tuser);
            r_in.operand           <= s_axis_tdata[7:0];
            r_in.effective_address <= s_axis_tdata[23:8];
            r_in.pc_step           <= s_axis_tdata[25:24];
        end
    end

    // state and beat counter: advance only when the execute stage fires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.acc    <= c6502_pkg::ACC_RESET;
            r_state.status <= c6502_pkg::STATUS_RESET;
            r_state.pc     <= c6502_pkg::PC_RESET;
            r_state.sp     <= c6502_pkg::SP_RESET;
            r_beat         <= 2'd0;
        end else if (exec_fire) begin
            r_beat <= n_beat;
            if (exec_done) begin
                r_state <= exec_next;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (exec_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out      <= exec_result;
            r_out_last <= exec_done;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out.invalid, r_out.write_enable};
    assign m_axis_tdata  = {r_out.pc_out, r_out.status_out, r_out.acc_out,
                            r_out.write_data, r_out.write_address};

endmodule

[rtl/core/c6502_exec.sv]
// ---------------------------------------------------------------------------
// c6502_exec
// Combinational execute step: next CPU state and one result beat.
// ---------------------------------------------------------------------------
module c6502_exec (
    input  c6502_pkg::t_instr     i_instr,
    input  c6502_pkg::t_cpu_state i_state,
    input  logic [15:0]           i_irq_vector,
    input  logic [1:0]            i_beat,
    output c6502_pkg::t_cpu_state o_next,
    output c6502_pkg::t_result    o_result,
    output logic                  o_multi_beat
);

    logic [8:0]  sum;
    logic [7:0]  res;
    logic [15:0] pc_two;
    logic [15:0] offset;
    logic        taken;
    logic [7:0]  sp_slot;

    always_comb begin
        sum     = {1'b0, i_state.acc} + {1'b0, i_instr.operand}
                  + {8'd0, i_state.status[c6502_pkg::FLAG_C]};
        pc_two  = i_state.pc + 16'd2;
        offset  = {{8{i_instr.operand[7]}}, i_instr.operand};
        sp_slot = i_state.sp - {6'd0, i_beat};
        res     = 8'd0;
        taken   = 1'b0;

        o_next       = i_state;
        o_multi_beat = 1'b0;
        o_result     = '0;

        unique case (i_instr.kind)
            c6502_pkg::KIND_ADC: begin
                res = sum[7:0];
                o_next.acc = res;
                o_next.status[c6502_pkg::FLAG_C] = sum[8];
                o_next.status[c6502_pkg::FLAG_V] =
                    (i_state.acc[7] ^ res[7]) & (i_instr.operand[7] ^ res[7]);
                o_next.status[c6502_pkg::FLAG_N] = res[7];
                o_next.status[c6502_pkg::FLAG_Z] = (res == 8'd0);
                o_next.pc = i_state.pc + {14'd0, i_instr.pc_step};
            end
            c6502_pkg::KIND_AND: begin
                res = i_state.acc & i_instr.operand;
                o_next.acc = res;
                o_next.status[c6502_pkg::FLAG_N] = res[7];
                o_next.status[c6502_pkg::FLAG_Z] = (res == 8'd0);
                o_next.pc = i_state.pc + {14'd0, i_instr.pc_step};
            end
            c6502_pkg::KIND_ASL_A: begin
                res = {i_state.acc[6:0], 1'b0};
                o_next.acc = res;
                o_next.status[c6502_pkg::FLAG_C] = i_state.acc[7];
                o_next.status[c6502_pkg::FLAG_N] = res[7];
                o_next.status[c6502_pkg::FLAG_Z] = (res == 8'd0);
                o_next.pc = i_state.pc + 16'd1;
            end
            c6502_pkg::KIND_ASL_MEM: begin
                res = {i_instr.operand[6:0], 1'b0};
                o_next.status[c6502_pkg::FLAG_C] = i_instr.operand[7];
                o_next.status[c6502_pkg::FLAG_N] = res[7];
                o_next.status[c6502_pkg::FLAG_Z] = (res == 8'd0);
                o_next.pc = i_state.pc + {14'd0, i_instr.pc_step};
                o_result.write_enable  = 1'b1;
                o_result.write_address = i_instr.effective_address;
                o_result.write_data    = res;
            end
            c6502_pkg::KIND_BIT: begin
                o_next.status[c6502_pkg::FLAG_N] = i_instr.operand[7];
                o_next.status[c6502_pkg::FLAG_V] = i_instr.operand[6];
                o_next.status[c6502_pkg::FLAG_Z] = ((i_state.acc & i_instr.operand) == 8'd0);
                o_next.pc = i_state.pc + {14'd0, i_instr.pc_step};
            end
            c6502_pkg::KIND_BCC, c6502_pkg::KIND_BCS, c6502_pkg::KIND_BEQ,
            c6502_pkg::KIND_BMI, c6502_pkg::KIND_BNE, c6502_pkg::KIND_BPL,
            c6502_pkg::KIND_BVC, c6502_pkg::KIND_BVS: begin
                unique case (i_instr.kind)
                    c6502_pkg::KIND_BCC: taken = !i_state.status[c6502_pkg::FLAG_C];
                    c6502_pkg::KIND_BCS: taken =  i_state.status[c6502_pkg::FLAG_C];
                    c6502_pkg::KIND_BEQ: taken =  i_state.status[c6502_pkg::FLAG_Z];
                    c6502_pkg::KIND_BMI: taken =  i_state.status[c6502_pkg::FLAG_N];
                    c6502_pkg::KIND_BNE: taken = !i_state.status[c6502_pkg::FLAG_Z];
                    c6502_pkg::KIND_BPL: taken = !i_state.status[c6502_pkg::FLAG_N];
                    c6502_pkg::KIND_BVC: taken = !i_state.status[c6502_pkg::FLAG_V];
                    default:             taken =  i_state.status[c6502_pkg::FLAG_V];
                endcase
                o_next.pc = taken ? (pc_two + offset) : pc_two;
            end
            c6502_pkg::KIND_BRK: begin
                o_multi_beat = 1'b1;
                o_next.sp = i_state.sp - 8'd3;
                o_next.pc = i_irq_vector;
                o_result.write_enable  = 1'b1;
                o_result.write_address = {c6502_pkg::STACK_PAGE, sp_slot};
                unique case (i_beat)
                    2'd0:    o_result.write_data = pc_two[15:8];
                    2'd1:    o_result.write_data = pc_two[7:0];
                    default: o_result.write_data = i_state.status | c6502_pkg::BRK_PUSH_MASK;
                endcase
            end
            default: begin
                // invalid opcode: state unchanged
                o_result.invalid = 1'b1;
            end
        endcase

        o_result.acc_out    = o_next.acc;
        o_result.status_out = o_next.status;
        o_result.pc_out     = o_next.pc;
    end

endmodule

[rtl/core/c6502_checker.sv]
// ---------------------------------------------------------------------------
// c6502_checker
// Port-level checks on the result stream of the 6502 ALU/branch block.
// ---------------------------------------------------------------------------
`include "cpu6502_alu_branch_ops_macros.svh"

module c6502_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled beat holds
    `C6502_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)), "result changed while stalled")

    // an invalid opcode gives a single beat without a write
    `C6502_ASSERT(a_invalid_no_write, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser[1]) |-> (!m_axis_tuser[0] && m_axis_tlast), "invalid opcode carried a write")

    // only BRK has beats before the last, and each is a stack write
    `C6502_ASSERT(a_mid_beat_stack, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[0] && (m_axis_tdata[15:8] == 8'h01)), "non-final beat is not a stack write")

    // the next BRK beat follows at once and carries the same A, P and PC
    `C6502_ASSERT(a_brk_beats_agree, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && $stable(m_axis_tdata[55:24])), "BRK beats disagree on state")

    // reset empties the result register
    `C6502_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind cpu6502_alu_branch_ops c6502_checker u_c6502_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the 6502 ALU, flag-branch and BRK execution block.
// A queue of instructions feeds a stream driver; a clocked monitor runs an
// independent model of A, P, PC, SP and the IRQ vector on every accepted
// instruction and compares each result beat field by field.
// ---------------------------------------------------------------------------
module tb;

    // kind 15 is not named in the package; it must decode as invalid
    localparam logic [3:0] KIND_UNUSED    = 4'hF;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         RANDOM_PHASE   = 60;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  operand;
        logic [15:0] ea;
        logic [1:0]  pc_step;
    } t_item;

    typedef struct packed {
        c6502_pkg::t_result res;
        logic               final_beat;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [3:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    cpu6502_alu_branch_ops i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // instructions waiting for the driver, and beats the model has predicted
    t_item pending_instrs[$];
    t_beat expected_beats[$];

    // model copy of the CPU state and the IRQ vector
    logic [7:0]  acc_q;
    logic [7:0]  status_q;
    logic [15:0] pc_q;
    logic [7:0]  sp_q;
    logic [15:0] irq_q;

    logic instr_taken  = 1'b0;
    int   gap_left     = 0;
    int   stall_left   = 0;
    int   quiet_cycles = 0;
    int   error_count  = 0;
    bit   no_idle      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Idle length: mostly none, often a few cycles, now and then a long pause.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q                    = p;
        q[c6502_pkg::FLAG_N] = v[7];
        q[c6502_pkg::FLAG_Z] = (v == 8'h00);
        return q;
    endfunction

    // Queue one beat carrying the model state as it stands after the instruction.
    task automatic push_beat(input logic wr, input logic [15:0] addr,
                             input logic [7:0] data, input logic inv,
                             input logic fin);
        t_beat b;
        b.res.write_enable  = wr;
        b.res.write_address = addr;
        b.res.write_data    = data;
        b.res.acc_out       = acc_q;
        b.res.status_out    = status_q;
        b.res.pc_out        = pc_q;
        b.res.invalid       = inv;
        b.final_beat        = fin;
        expected_beats.push_back(b);
    endtask

    // Execute one instruction on the model state and queue the beats it yields.
    task automatic execute_instruction(input logic [3:0] kind, input logic [7:0] op,
                                       input logic [15:0] ea, input logic [1:0] step);
        logic [7:0]  p;
        logic [7:0]  res;
        logic [8:0]  sum;
        logic [15:0] ret;
        logic [7:0]  sp0;
        logic        taken;
        p     = status_q;
        taken = 1'b0;
        case (kind)
            c6502_pkg::KIND_ADC: begin
                sum = {1'b0, acc_q} + {1'b0, op} + {8'h00, p[c6502_pkg::FLAG_C]};
                res = sum[7:0];
                status_q[c6502_pkg::FLAG_C] = sum[8];
                status_q[c6502_pkg::FLAG_V] = (acc_q[7] ^ res[7]) & (op[7] ^ res[7]);
                acc_q    = res;
                status_q = with_nz(status_q, res);
                pc_q     = pc_q + {14'h0, step};
            end
            c6502_pkg::KIND_AND: begin
                acc_q    = acc_q & op;
                status_q = with_nz(p, acc_q);
                pc_q     = pc_q + {14'h0, step};
            end
            c6502_pkg::KIND_ASL_A: begin
                status_q[c6502_pkg::FLAG_C] = acc_q[7];
                acc_q    = {acc_q[6:0], 1'b0};
                status_q = with_nz(status_q, acc_q);
                pc_q     = pc_q + 16'd1;
            end
            c6502_pkg::KIND_ASL_MEM: begin
                res = {op[6:0], 1'b0};
                status_q[c6502_pkg::FLAG_C] = op[7];
                status_q = with_nz(status_q, res);
                pc_q     = pc_q + {14'h0, step};
                push_beat(1'b1, ea, res, 1'b0, 1'b1);
            end
            c6502_pkg::KIND_BIT: begin
                status_q[c6502_pkg::FLAG_N] = op[7];
                status_q[c6502_pkg::FLAG_V] = op[6];
                status_q[c6502_pkg::FLAG_Z] = ((acc_q & op) == 8'h00);
                pc_q = pc_q + {14'h0, step};
            end
            c6502_pkg::KIND_BCC, c6502_pkg::KIND_BCS, c6502_pkg::KIND_BEQ,
            c6502_pkg::KIND_BMI, c6502_pkg::KIND_BNE, c6502_pkg::KIND_BPL,
            c6502_pkg::KIND_BVC, c6502_pkg::KIND_BVS: begin
                case (kind)
                    c6502_pkg::KIND_BCC: taken = !p[c6502_pkg::FLAG_C];
                    c6502_pkg::KIND_BCS: taken =  p[c6502_pkg::FLAG_C];
                    c6502_pkg::KIND_BEQ: taken =  p[c6502_pkg::FLAG_Z];
                    c6502_pkg::KIND_BMI: taken =  p[c6502_pkg::FLAG_N];
                    c6502_pkg::KIND_BNE: taken = !p[c6502_pkg::FLAG_Z];
                    c6502_pkg::KIND_BPL: taken = !p[c6502_pkg::FLAG_N];
                    c6502_pkg::KIND_BVC: taken = !p[c6502_pkg::FLAG_V];
                    default:             taken =  p[c6502_pkg::FLAG_V];
                endcase
                // offset is a signed byte; wrap within 16 bits
                pc_q = pc_q + 16'd2 + (taken ? {{8{op[7]}}, op} : 16'h0000);
            end
            c6502_pkg::KIND_BRK: begin
                ret  = pc_q + 16'd2;
                sp0  = sp_q;
                sp_q = sp_q - 8'd3;
                pc_q = irq_q;
                push_beat(1'b1, {c6502_pkg::STACK_PAGE, sp0}, ret[15:8], 1'b0, 1'b0);
                push_beat(1'b1, {c6502_pkg::STACK_PAGE, sp0 - 8'd1}, ret[7:0], 1'b0, 1'b0);
                push_beat(1'b1, {c6502_pkg::STACK_PAGE, sp0 - 8'd2},
                          p | c6502_pkg::BRK_PUSH_MASK, 1'b0, 1'b1);
            end
            default: begin
                push_beat(1'b0, 16'h0000, 8'h00, 1'b1, 1'b1);
            end
        endcase
        // every valid instruction without a write gives one plain beat
        if (kind <= c6502_pkg::KIND_BVS && kind != c6502_pkg::KIND_ASL_MEM)
            push_beat(1'b0, 16'h0000, 8'h00, 1'b0, 1'b1);
    endtask

    // -----------------------------------------------------------------------
    // Driver: present queued instructions at the falling edge, hold each one
    // until its transaction completes, then idle for a random gap (none when idling is off).
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_item nxt;
        if (s_axis_tvalid && !instr_taken) begin
            // hold the current transaction
        end else if (gap_left != 0) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= gap_left - 1;
        end else if (pending_instrs.size() != 0) begin
            nxt            = pending_instrs.pop_front();
            s_axis_tuser  <= nxt.kind;
            s_axis_tdata  <= {6'b000000, nxt.pc_step, nxt.ea, nxt.operand};
            s_axis_tvalid <= 1'b1;
            gap_left      <= no_idle ? 0 : idle_len();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure: random stalls of the same shape as the sender's gaps.
    always @(negedge i_clk) begin : receiver
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                stall_left <= idle_len();
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: at the rising edge, track register writes, predict from each
    // accepted instruction and check each accepted result beat.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_beat got;
        t_beat want;
        logic  in_fire;
        logic  out_fire;
        in_fire  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (!i_rst_n) begin
            acc_q    = c6502_pkg::ACC_RESET;
            status_q = c6502_pkg::STATUS_RESET;
            pc_q     = c6502_pkg::PC_RESET;
            sp_q     = c6502_pkg::SP_RESET;
            irq_q    = c6502_pkg::IRQ_VECTOR_RESET;
        end else begin
            if (i_cfg_wr_en)
                irq_q = i_cfg_wr_data;
            if (in_fire)
                execute_instruction(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8],
                                    s_axis_tdata[25:24]);
            if (out_fire) begin
                got.res.write_enable  = m_axis_tuser[0];
                got.res.invalid       = m_axis_tuser[1];
                got.res.write_address = m_axis_tdata[15:0];
                got.res.write_data    = m_axis_tdata[23:16];
                got.res.acc_out       = m_axis_tdata[31:24];
                got.res.status_out    = m_axis_tdata[39:32];
                got.res.pc_out        = m_axis_tdata[55:40];
                got.final_beat        = m_axis_tlast;
                if (expected_beats.size() == 0) begin
                    report_mismatch("result with nothing expected, pc_out",
                                    got.res.pc_out, 16'h0000);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.res.write_enable !== want.res.write_enable)
                        report_mismatch("write_enable", 16'(got.res.write_enable),
                                        16'(want.res.write_enable));
                    if (got.res.write_address !== want.res.write_address)
                        report_mismatch("write_address", got.res.write_address,
                                        want.res.write_address);
                    if (got.res.write_data !== want.res.write_data)
                        report_mismatch("write_data", 16'(got.res.write_data),
                                        16'(want.res.write_data));
                    if (got.res.acc_out !== want.res.acc_out)
                        report_mismatch("acc_out", 16'(got.res.acc_out),
                                        16'(want.res.acc_out));
                    if (got.res.status_out !== want.res.status_out)
                        report_mismatch("status_out", 16'(got.res.status_out),
                                        16'(want.res.status_out));
                    if (got.res.pc_out !== want.res.pc_out)
                        report_mismatch("pc_out", got.res.pc_out, want.res.pc_out);
                    if (got.res.invalid !== want.res.invalid)
                        report_mismatch("invalid", 16'(got.res.invalid),
                                        16'(want.res.invalid));
                    if (got.final_beat !== want.final_beat)
                        report_mismatch("tlast", 16'(got.final_beat),
                                        16'(want.final_beat));
                end
            end
        end
        instr_taken  <= in_fire;
        quiet_cycles <= (!i_rst_n || in_fire || out_fire) ? 0 : quiet_cycles + 1;
    end

    // Watchdog: end the run if no transaction moves on either side for too long.
    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic add_instr(input logic [3:0] kind, input logic [7:0] op,
                             input logic [15:0] ea, input logic [1:0] step);
        t_item it;
        it.kind    = kind;
        it.operand = op;
        it.ea      = ea;
        it.pc_step = step;
        pending_instrs.push_back(it);
    endtask

    // Random instruction: heavy on BRK so that many stack pushes occur,
    // and on branches so both outcomes of each flag test turn up.
    function automatic t_item random_instruction();
        t_item it;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 15)
            it.kind = c6502_pkg::KIND_ADC;
        else if (r < 23)
            it.kind = c6502_pkg::KIND_AND;
        else if (r < 31)
            it.kind = c6502_pkg::KIND_ASL_A;
        else if (r < 41)
            it.kind = c6502_pkg::KIND_ASL_MEM;
        else if (r < 49)
            it.kind = c6502_pkg::KIND_BIT;
        else if (r < 74)
            it.kind = 4'(c6502_pkg::KIND_BCC) + 4'($urandom_range(0, 7));
        else if (r < 96)
            it.kind = c6502_pkg::KIND_BRK;
        else if (r < 98)
            it.kind = c6502_pkg::KIND_INVALID;
        else
            it.kind = KIND_UNUSED;
        case ($urandom_range(0, 11))
            0:       it.operand = 8'h00;
            1:       it.operand = 8'h7F;
            2:       it.operand = 8'h80;
            3:       it.operand = 8'hFF;
            default: it.operand = 8'($urandom_range(0, 255));
        endcase
        it.ea      = 16'($urandom_range(0, 65535));
        it.pc_step = 2'($urandom_range(0, 3));
        return it;
    endfunction

    // Let the block drain: no instruction left to send and every beat back.
    task automatic wait_idle();
        while (pending_instrs.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_irq_vector(input logic [15:0] vec);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= vec;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Stimulus: reset, a directed run on the reset vector, then random phases
    // each under a fresh IRQ vector, the extremes among them.
    // -----------------------------------------------------------------------
    initial begin : stimulus
        logic [15:0] vectors [5];
        vectors[0] = 16'h0000;
        vectors[1] = 16'hFFFF;
        vectors[2] = 16'($urandom_range(0, 65535));
        vectors[3] = 16'h8000;
        vectors[4] = 16'($urandom_range(0, 65535));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed run from A=00, P=24, PC=0000, SP=FD, vector FFFF.
        add_instr(c6502_pkg::KIND_ADC,     8'h00, 16'h0000, 2'd2);  // zero result
        add_instr(c6502_pkg::KIND_ADC,     8'h7F, 16'hFFFF, 2'd2);
        add_instr(c6502_pkg::KIND_ADC,     8'h01, 16'h0000, 2'd3);  // signed overflow to 80
        add_instr(c6502_pkg::KIND_ADC,     8'h80, 16'h0000, 2'd0);  // 80+80: C, V, zero
        add_instr(c6502_pkg::KIND_ADC,     8'hFF, 16'h0000, 2'd1);  // carry in rolls over
        add_instr(c6502_pkg::KIND_AND,     8'hFF, 16'h0000, 2'd2);
        add_instr(c6502_pkg::KIND_ADC,     8'hC0, 16'h0000, 2'd2);
        add_instr(c6502_pkg::KIND_ASL_A,   8'h00, 16'hFFFF, 2'd3);  // bit 7 out to carry
        add_instr(c6502_pkg::KIND_ASL_MEM, 8'h80, 16'hFFFF, 2'd3);  // top address, zero
        add_instr(c6502_pkg::KIND_ASL_MEM, 8'h41, 16'h0000, 2'd0);
        add_instr(c6502_pkg::KIND_BIT,     8'hC0, 16'h0000, 2'd2);  // N and V from operand
        add_instr(c6502_pkg::KIND_BIT,     8'h00, 16'h0000, 2'd1);  // Z from A AND operand
        add_instr(c6502_pkg::KIND_BCC,     8'h80, 16'h0000, 2'd0);  // most negative offset
        add_instr(c6502_pkg::KIND_BCS,     8'h7F, 16'h0000, 2'd0);  // most positive offset
        add_instr(c6502_pkg::KIND_BEQ,     8'h7F, 16'h0000, 2'd0);
        add_instr(c6502_pkg::KIND_BMI,     8'h00, 16'h0000, 2'd0);
        add_instr(c6502_pkg::KIND_BNE,     8'h10, 16'h0000, 2'd0);
        add_instr(c6502_pkg::KIND_BPL,     8'hFE, 16'h0000, 2'd0);
        add_instr(c6502_pkg::KIND_BVC,     8'h80, 16'h0000, 2'd0);
        add_instr(c6502_pkg::KIND_BVS,     8'h7F, 16'h0000, 2'd0);
        add_instr(c6502_pkg::KIND_BRK,     8'h00, 16'h0000, 2'd0);  // PC lands on FFFF
        add_instr(c6502_pkg::KIND_BCC,     8'h05, 16'h0000, 2'd3);  // PC wraps past FFFF
        add_instr(c6502_pkg::KIND_INVALID, 8'hFF, 16'hFFFF, 2'd3);  // state must not move
        add_instr(KIND_UNUSED,             8'hFF, 16'hFFFF, 2'd3);
        add_instr(c6502_pkg::KIND_BRK,     8'hFF, 16'hFFFF, 2'd3);
        wait_idle();

        // Random phases; one of them runs with no idling on either side.
        foreach (vectors[ph]) begin
            no_idle = (ph == 3);
            write_irq_vector(vectors[ph]);
            repeat (RANDOM_PHASE) pending_instrs.push_back(random_instruction());
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        while (expected_beats.size() != 0) begin
            report_mismatch("result never arrived, pc_out",
                            16'h0000, expected_beats[0].res.pc_out);
            void'(expected_beats.pop_front());
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/c6502_pkg.sv
rtl/core/c6502_exec.sv
rtl/core/cpu6502_alu_branch_ops.sv
rtl/core/c6502_checker.sv
sim/tb.sv
